// ===== hw/rtl/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	localparam int ADDR_W = 32;
	localparam int BB_W   = 16;
	localparam int CNT_W  = 7;
	localparam int SPAN_W = BB_W + CNT_W;
	localparam int PROD_W = BB_W + IDX_W;
	localparam int DIV_W  = BB_W + IDX_W;
	localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [ADDR_W-1:0] RST_BASE        = 32'd0;
	localparam logic [BB_W-1:0]   RST_BLOCK_BYTES = 16'd32;
	localparam logic [CNT_W-1:0]  RST_COUNT       = 7'd64;
	localparam logic [BB_W-1:0]   MIN_BLOCK_BYTES = 16'd4;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_NOT_SERVED = 3'd1,
		ST_RETURNED   = 3'd2,
		ST_OUTSIDE    = 3'd3,
		ST_NULL       = 3'd4
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] request_bytes;
		logic [ADDR_W-1:0] release_address;
	} req_item_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted_address;
		logic [CNT_W-1:0]  used_blocks;
	} res_item_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [BB_W-1:0]   bb;
		logic [CNT_W-1:0]  n;
	} cfg_t;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_REFUSE,
		CMD_RELEASE,
		CMD_OUTSIDE,
		CMD_NULL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] link;
	} link_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SPAN,
		F_CHECK,
		F_DIV,
		F_PUSH
	} fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_GRANT
	} bstate_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fbfl_front.sv =====
// ----------------------------------------------------------------------------
// fbfl_front
// Takes requests, sorts them (size check, null, pool range) and turns a
// release address into a block index with a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fbfl_pkg::req_item_t request,
	input  fbfl_pkg::cfg_t    cfg,
	output logic              push,
	output fbfl_pkg::cmd_t    push_cmd,
	input  logic              q_full
);
	import fbfl_pkg::*;

	fstate_t state_q, state_d;

	req_item_t          item_q;
	logic [SPAN_W-1:0]  span_q;
	logic [ADDR_W-1:0]  rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [IDX_W-1:0]   quo_q;
	logic [STEP_W-1:0]  step_q;
	cmd_t               cmd_q;

	logic               in_range;
	logic               ge;
	logic [IDX_W-1:0]   quo_next;
	logic [ADDR_W:0]    pool_hi;

	assign pool_hi  = {1'b0, cfg.base} + (ADDR_W+1)'(span_q);
	assign in_range = (item_q.release_address >= cfg.base) &&
	                  ({1'b0, item_q.release_address} < pool_hi);
	assign ge       = rem_q >= ADDR_W'(div_q);
	assign quo_next = IDX_W'({quo_q, ge});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (start) state_d = F_SPAN;
			end
			F_SPAN: begin
				state_d = (item_q.mode == MODE_ALLOC) ? F_PUSH : F_CHECK;
			end
			F_CHECK: begin
				if (item_q.release_address != '0 && in_range) state_d = F_DIV;
				else state_d = F_PUSH;
			end
			F_DIV: begin
				if (step_q == '0) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy     = state_q != F_IDLE;
		push     = (state_q == F_PUSH) && !q_full;
		push_cmd = cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start) item_q <= request;
			end
			F_SPAN: begin
				span_q    <= SPAN_W'(cfg.bb) * SPAN_W'(cfg.n);
				cmd_q.idx <= '0;
				if (ADDR_W'(cfg.bb) < item_q.request_bytes) cmd_q.kind <= CMD_REFUSE;
				else cmd_q.kind <= CMD_ALLOC;
			end
			F_CHECK: begin
				rem_q  <= item_q.release_address - cfg.base;
				div_q  <= DIV_W'(cfg.bb) << (IDX_W - 1);
				quo_q  <= '0;
				step_q <= STEP_W'(IDX_W - 1);
				if (item_q.release_address == '0) cmd_q.kind <= CMD_NULL;
				else if (!in_range) cmd_q.kind <= CMD_OUTSIDE;
			end
			F_DIV: begin
				// restoring division, offset < bb * 2^IDX_W so IDX_W steps suffice
				if (ge) rem_q <= rem_q - ADDR_W'(div_q);
				div_q     <= div_q >> 1;
				quo_q     <= quo_next;
				step_q    <= step_q - STEP_W'(1);
				cmd_q.idx <= quo_next;
				if (step_q == '0) cmd_q.kind <= CMD_RELEASE;
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fbfl_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbfl_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output fbfl_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import fbfl_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_back.sv =====
// ----------------------------------------------------------------------------
// fbfl_back
// Runs queued commands against the LIFO free list: pops on a grant, pushes
// on a release, keeps the used count and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fbfl_pkg::cfg_t      cfg,
	input  logic                rebuild,
	input  logic                q_empty,
	input  fbfl_pkg::cmd_t      q_cmd,
	output logic                pop,
	output logic                done,
	output fbfl_pkg::res_item_t result
);
	import fbfl_pkg::*;

	bstate_t state_q, state_d;

	cmd_t                  cmd_q;
	logic [IDX_W-1:0]      top_q;
	logic                  top_vld_q;
	logic [CNT_W-1:0]      used_q;
	logic [MAX_BLOCKS-1:0] written_q;

	link_t                 link_mem [MAX_BLOCKS];
	link_t                 rd_q;
	logic                  rd_written_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic [PROD_W-1:0]     prod_q;

	link_t                 link_rd;
	logic                  mem_we;
	logic                  emit;
	res_item_t             res_d;
	res_item_t             res_q;
	logic                  done_q;
	logic [CNT_W-1:0]      used_inc;
	logic [CNT_W-1:0]      used_dec;

	// a link never written since the last rebuild points at the block below
	always_comb begin
		if (rd_written_q) begin
			link_rd = rd_q;
		end else begin
			link_rd.vld  = rd_addr_q != '0;
			link_rd.link = rd_addr_q - IDX_W'(1);
		end
	end

	assign used_inc = (used_q < cfg.n) ? used_q + CNT_W'(1) : used_q;
	assign used_dec = (used_q != '0) ? used_q - CNT_W'(1) : used_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_EXEC;
			end
			B_EXEC: begin
				if (cmd_q.kind == CMD_ALLOC && top_vld_q) state_d = B_GRANT;
				else state_d = B_IDLE;
			end
			B_GRANT: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop                   = 1'b0;
		mem_we                = 1'b0;
		emit                  = 1'b0;
		res_d.status          = ST_NULL;
		res_d.granted_address = '0;
		res_d.used_blocks     = used_q;
		unique case (state_q)
			B_IDLE: pop = !q_empty;
			B_EXEC: begin
				unique case (cmd_q.kind)
					CMD_ALLOC: begin
						if (!top_vld_q) begin
							emit         = 1'b1;
							res_d.status = ST_NOT_SERVED;
						end
					end
					CMD_REFUSE: begin
						emit         = 1'b1;
						res_d.status = ST_NOT_SERVED;
					end
					CMD_RELEASE: begin
						mem_we            = 1'b1;
						emit              = 1'b1;
						res_d.status      = ST_RETURNED;
						res_d.used_blocks = used_dec;
					end
					CMD_OUTSIDE: begin
						emit         = 1'b1;
						res_d.status = ST_OUTSIDE;
					end
					CMD_NULL: begin
						emit         = 1'b1;
						res_d.status = ST_NULL;
					end
					default: begin
					end
				endcase
			end
			B_GRANT: begin
				emit                  = 1'b1;
				res_d.status          = ST_GRANTED;
				res_d.granted_address = cfg.base + ADDR_W'(prod_q);
				res_d.used_blocks     = used_inc;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			top_q     <= '0;
			top_vld_q <= 1'b1;
			used_q    <= '0;
			written_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (rebuild) begin
				top_q     <= IDX_W'(cfg.n - CNT_W'(1));
				top_vld_q <= 1'b1;
				used_q    <= '0;
				written_q <= '0;
			end else if (mem_we) begin
				written_q[cmd_q.idx] <= 1'b1;
				top_q                <= cmd_q.idx;
				top_vld_q            <= 1'b1;
				used_q               <= used_dec;
			end else if (state_q == B_GRANT) begin
				top_q     <= link_rd.link;
				top_vld_q <= link_rd.vld;
				used_q    <= used_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_cmd;
		if (emit) res_q <= res_d;
		prod_q <= PROD_W'(top_q) * PROD_W'(cfg.bb);
	end

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[cmd_q.idx] <= '{vld: top_vld_q, link: top_q};
		rd_q         <= link_mem[top_q];
		rd_written_q <= written_q[top_q];
		rd_addr_q    <= top_q;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Fixed-size block pool with a LIFO free list of block indices.
//
//   channel   signals                        handshake
//   request   start, busy, request           beat when start && !busy
//   result    done, result                   one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_data    beat when cfg_we
//
// Accept to result: the front passes SPAN, for a release also CHECK and, if
// in the pool, the divider (6-step, one quotient bit a cycle), then PUSH into
// the command queue; the back pops it, executes it and, for a grant, goes via
// GRANT before the registered result beat. The front takes the next beat only
// after pushing the current command; busy also holds while the 2-deep command
// queue is full. Reset and base, block or count writes rebuild the free list.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  fbfl_pkg::req_item_t                request,
	output logic                               done,
	output fbfl_pkg::res_item_t                result,
	input  logic                               cfg_we,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fbfl_pkg::*;

	logic [ADDR_W-1:0] base_q;
	logic [BB_W-1:0]   block_bytes_q;
	logic [CNT_W-1:0]  count_q;
	logic              rebuild_q;
	cfg_t              cfg;

	logic              push;
	cmd_t              push_cmd;
	logic              q_full;
	logic              pop;
	cmd_t              pop_cmd;
	logic              q_empty;

	always_comb begin
		cfg.base = base_q;
		cfg.bb   = (block_bytes_q < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes_q;
		if (count_q == '0) cfg.n = CNT_W'(1);
		else if (32'(count_q) > 32'(MAX_BLOCKS)) cfg.n = CNT_W'(MAX_BLOCKS);
		else cfg.n = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= RST_BASE;
			block_bytes_q <= RST_BLOCK_BYTES;
			count_q       <= RST_COUNT;
			rebuild_q     <= 1'b1;
		end else begin
			rebuild_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE: begin
						base_q    <= cfg_data;
						rebuild_q <= 1'b1;
					end
					CFG_BLOCK: begin
						block_bytes_q <= cfg_data[BB_W-1:0];
						rebuild_q     <= 1'b1;
					end
					CFG_COUNT: begin
						count_q   <= cfg_data[CNT_W-1:0];
						rebuild_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	fbfl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.cfg      (cfg),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	fbfl_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	fbfl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rebuild (rebuild_q),
		.q_empty (q_empty),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_checker.sv =====
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks on the allocator top, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input fbfl_pkg::res_item_t result
);
	import fbfl_pkg::*;

	// a beat on the request side always occupies the front
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted beat");

	// the back returns to idle after every result, so result beats never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats in consecutive cycles");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_GRANTED) |-> (result.granted_address == '0))
		else $error("address on a result that granted nothing");

	a_grant_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_GRANTED) |-> (result.used_blocks != '0))
		else $error("grant with zero blocks in use");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_checker (.*);

`default_nettype wire

// ===== tb/fixed_block_free_list_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_checker
// Watches the request, result and config ports of the block pool allocator.
// It keeps its own copy of the free list and configuration, works out the
// result of every accepted request and compares them in order with the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator_checker
	import fbfl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  req_item_t             request,
	input  logic                  done,
	input  res_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    mismatches
);

	// raw register contents, clamped only where used
	logic [ADDR_W-1:0] base_r;
	logic [BB_W-1:0]   bb_r;
	logic [CNT_W-1:0]  count_r;

	logic [IDX_W-1:0]  top_idx;
	logic              top_vld;
	link_t             links [MAX_BLOCKS];
	logic [CNT_W-1:0]  used;

	res_item_t         expected_results [$];

	function automatic logic [CNT_W-1:0] clamped_count();
		if (count_r == '0)
			return CNT_W'(1);
		if (count_r > CNT_W'(MAX_BLOCKS))
			return CNT_W'(MAX_BLOCKS);
		return count_r;
	endfunction

	// last block on top, each block pointing at the one below, block 0 at the bottom
	function automatic void rebuild_list();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			links[i].link = (i == 0) ? '0 : IDX_W'(i - 1);
			links[i].vld  = (i != 0);
		end
		top_idx = IDX_W'(clamped_count() - 1);
		top_vld = 1'b1;
		used    = '0;
	endfunction

	function automatic res_item_t serve_request(req_item_t rq);
		logic [BB_W-1:0]  bb;
		logic [CNT_W-1:0] n;
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [63:0]      offs;
		logic [IDX_W-1:0] idx;
		res_item_t        rs;
		bb = (bb_r < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : bb_r;
		n  = clamped_count();
		rs.status          = ST_NOT_SERVED;
		rs.granted_address = '0;
		if (rq.mode == MODE_ALLOC) begin
			if (top_vld && rq.request_bytes <= 32'(bb)) begin
				idx = top_idx;
				rs.granted_address = base_r + 32'(idx) * 32'(bb);
				rs.status = ST_GRANTED;
				top_vld = links[idx].vld;
				top_idx = links[idx].link;
				if (used < n)
					used = used + 1'b1;
			end
		end else if (rq.release_address == '0) begin
			rs.status = ST_NULL;
		end else begin
			// range check without 32-bit wrap
			lo = 64'(base_r);
			hi = lo + 64'(bb) * 64'(n);
			if (64'(rq.release_address) >= lo && 64'(rq.release_address) < hi) begin
				offs = (64'(rq.release_address) - lo) / 64'(bb);
				idx  = (offs >= 64'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS - 1) : IDX_W'(offs);
				links[idx].link = top_idx;
				links[idx].vld  = top_vld;
				top_idx = idx;
				top_vld = 1'b1;
				if (used > '0)
					used = used - 1'b1;
				rs.status = ST_RETURNED;
			end else begin
				rs.status = ST_OUTSIDE;
			end
		end
		rs.used_blocks = used;
		return rs;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			base_r  = RST_BASE;
			bb_r    = RST_BLOCK_BYTES;
			count_r = RST_COUNT;
			rebuild_list();
			expected_results.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE: begin
						base_r = cfg_data;
						rebuild_list();
					end
					CFG_BLOCK: begin
						bb_r = cfg_data[BB_W-1:0];
						rebuild_list();
					end
					CFG_COUNT: begin
						count_r = cfg_data[CNT_W-1:0];
						rebuild_list();
					end
					default: ;
				endcase
			end
			// compare before queuing this edge's request: a result can't be its own
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no result expected");
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errs++;
					end
					if (result.granted_address !== want.granted_address) begin
						$error("granted_address: expected %h, got %h",
							want.granted_address, result.granted_address);
						errs++;
					end
					if (result.used_blocks !== want.used_blocks) begin
						$error("used_blocks: expected %0d, got %0d",
							want.used_blocks, result.used_blocks);
						errs++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(serve_request(request));
			pending    <= expected_results.size();
			mismatches <= mismatches + errs;
		end
	end

endmodule

`default_nettype wire

// ===== tb/fixed_block_free_list_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top_tb
// Drives directed and random allocate/release traffic into the block pool
// allocator across several pool configurations, with random idle gaps, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator_top_tb;
	import fbfl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int STALL_LIMIT     = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	req_item_t             request = '0;
	logic                  done;
	res_item_t             result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    pending;
	int                    mismatches;

	// effective pool layout, for aiming releases
	logic [ADDR_W-1:0]     layout_base = RST_BASE;
	logic [BB_W-1:0]       pool_bb = RST_BLOCK_BYTES;
	logic [CNT_W-1:0]      pool_n = RST_COUNT;
	bit                    quiet = 1'b0;

	always #2 clk = ~clk;

	fixed_block_free_list_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fixed_block_free_list_allocator_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.mismatches (mismatches)
	);

	task automatic send(input req_item_t item);
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause();
		if (!quiet) begin
			while ($urandom_range(99) < 18) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// first edge lets the checker count the last beat
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] base, input logic [BB_W-1:0] bb,
			input logic [CNT_W-1:0] n);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= CFG_BLOCK;
		cfg_data  <= {16'($urandom), bb};
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_data  <= {25'($urandom), n};
		@(posedge clk);
		cfg_we    <= 1'b0;
		layout_base = base;
		pool_bb   = (bb < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : bb;
		pool_n    = (n == '0) ? CNT_W'(1) : (n > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : n;
	endtask

	function automatic req_item_t make_alloc(input logic [ADDR_W-1:0] bytes);
		req_item_t it;
		it.mode            = MODE_ALLOC;
		it.request_bytes   = bytes;
		it.release_address = $urandom;
		return it;
	endfunction

	function automatic req_item_t make_release(input logic [ADDR_W-1:0] addr);
		req_item_t it;
		it.mode            = MODE_RELEASE;
		it.request_bytes   = $urandom;
		it.release_address = addr;
		return it;
	endfunction

	// mostly fitting allocs and releases of real blocks, some noise
	function automatic req_item_t random_item();
		req_item_t   it;
		int unsigned roll;
		logic [31:0] blk;
		it.request_bytes   = $urandom;
		it.release_address = $urandom;
		roll = $urandom_range(99);
		if (roll < 52) begin
			it.mode = MODE_ALLOC;
			if (roll < 45)
				it.request_bytes = $urandom_range(pool_bb);
			else if (roll < 49)
				it.request_bytes = 32'(pool_bb) + $urandom_range(1, 8);
		end else begin
			it.mode = MODE_RELEASE;
			blk = $urandom_range(pool_n - 1);
			if (roll < 80)
				it.release_address = layout_base + blk * pool_bb;
			else if (roll < 88)
				it.release_address = layout_base + blk * pool_bb + $urandom_range(pool_bb - 1);
			else if (roll < 92)
				it.release_address = '0;
			else if (roll < 96)
				it.release_address = layout_base - 1'b1;
			else if (roll < 98)
				it.release_address = layout_base + pool_n * pool_bb;
		end
		return it;
	endfunction

	initial begin
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_we)
				stalled = 0;
			else
				stalled++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [ADDR_W-1:0] base;
		logic [BB_W-1:0]   bb;
		logic [CNT_W-1:0]  n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset layout: base 0, 32-byte blocks, 64 blocks
		send(make_alloc(32'd0));
		send(make_alloc(32'd32));
		send(make_alloc(32'd33));
		send(make_alloc(32'hFFFF_FFFF));
		send(make_release(32'd0));              // null even though 0 is in the pool
		send(make_release(32'd2016 + 32'd5));   // unaligned
		send(make_release(32'd2048));           // one past the end
		send(make_release(32'hFFFF_FFFF));
		send(make_release(32'd32));
		send(make_release(32'd32));             // double release

		// pool running past 2^32: granted address wraps
		configure(32'hFFFF_0000, 16'hFFFF, 7'd64);
		send(make_alloc(32'd65535));
		send(make_release(32'hFFFF_0000 + 32'd63 * 32'd65535));
		send(make_release(32'hFFFE_FFFF));
		send(make_release(32'hFFFF_0000));
		send(make_release(32'hFFFF_FFFF));

		// block size and count below range: 4 bytes, one block
		configure(32'h0000_1000, 16'd3, 7'd0);
		send(make_alloc(32'd4));
		send(make_alloc(32'd0));                // list empty
		send(make_release(32'h0000_1003));
		send(make_release(32'h0000_1004));
		send(make_release(32'h0000_1000));      // used stays at zero
		send(make_alloc(32'd1));
		send(make_alloc(32'd2));                // used saturates at the count

		configure(32'h8000_0000, 16'd0, 7'd127);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we    <= 1'b0;
		send(make_alloc(32'd4));
		send(make_alloc(32'd5));

		for (int p = 0; p < PHASES; p++) begin
			base = $urandom;
			bb   = $urandom_range(4, 64);
			n    = $urandom_range(1, 64);
			case (p)
				1: begin
					base = '1;
					bb   = '1;
					n    = 7'd64;
				end
				2: begin
					bb = 16'd4;
					n  = 7'd1;
				end
				3: begin
					base = '0;
					bb   = 16'd2;
					n    = 7'd127;
				end
				5: bb = $urandom_range(65535);
				6: n = $urandom_range(65, 127);
				default: ;
			endcase
			configure(base, bb, n);
			quiet = (p == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 2 && i == ITEMS_PER_PHASE / 2)
					drain();
				pause();
				send(random_item());
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== fixed_block_free_list_allocator_top.f =====
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_front.sv
hw/rtl/fbfl_cmd_fifo.sv
hw/rtl/fbfl_back.sv
hw/rtl/fixed_block_free_list_allocator_top.sv
hw/rtl/fbfl_checker.sv
tb/fixed_block_free_list_allocator_checker.sv
tb/fixed_block_free_list_allocator_top_tb.sv
